// ----- hw/rtl/sbc_pkg.sv -----
// Package for the sphere/box contact pipeline: payload types, register codes, stage map.
package sbc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SPHERE_RADIUS = 2'd0;
    localparam logic [1:0] REG_HALF_SIZE_X   = 2'd1;
    localparam logic [1:0] REG_HALF_SIZE_Y   = 2'd2;
    localparam logic [1:0] REG_HALF_SIZE_Z   = 2'd3;

    localparam int CFG_W = 31;

    // Contact margin of 0.0001 in Q16.16 LSBs
    localparam logic [CFG_W-1:0] EPS_Q = 31'd7;

    typedef struct packed {
        logic signed [31:0] sphere_x;
        logic signed [31:0] sphere_y;
        logic signed [31:0] sphere_z;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic signed [31:0] box_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_i;
        logic signed [15:0] rot_j;
        logic signed [15:0] rot_k;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] contact_z;
        logic signed [31:0] depth_x;
        logic signed [31:0] depth_y;
        logic signed [31:0] depth_z;
    } out_t;

    // Stage map
    localparam int SQ_PER   = 2;                       // root iterations per stage
    localparam int SQ_ITER  = 32;
    localparam int SQ_STG   = SQ_ITER / SQ_PER;
    localparam int DIV_PER  = 2;                       // quotient bits per stage
    localparam int DIV_BITS = 33;
    localparam int DIV_STG  = (DIV_BITS + DIV_PER - 1) / DIV_PER;

    localparam int ST_M     = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_PR    = 2;
    localparam int ST_CLAMP = 3;
    localparam int ST_FACE  = 4;
    localparam int ST_SUM   = 5;
    localparam int ST_SQRT0 = 6;
    localparam int ST_NUM   = ST_SQRT0 + SQ_STG;
    localparam int ST_ADD   = ST_NUM + 1;
    localparam int ST_DIV0  = ST_ADD + 1;
    localparam int ST_SC    = ST_DIV0 + DIV_STG;
    localparam int ST_ROT   = ST_SC + 1;
    localparam int ST_OUT   = ST_ROT + 1;
    localparam int N_STG    = ST_OUT + 1;

    // Everything one item carries down the pipeline
    typedef struct {
        logic signed [19:0] m [9];      // rotation matrix, Q14, row*3+col
        logic signed [31:0] b [3];
        logic signed [32:0] d [3];
        logic signed [52:0] prod [9];
        logic signed [41:0] pr [3];
        logic signed [31:0] p [3];
        logic signed [31:0] dr [3];
        logic        [30:0] dmag [3];
        logic               border;
        logic               near;
        logic        [61:0] sq [3];
        logic               interior;
        logic               cand;
        logic               hit;
        logic        [63:0] sq_n;
        logic        [63:0] sq_r;
        logic        [31:0] root;
        logic        [61:0] num [3];
        logic        [63:0] rem [3];
        logic        [32:0] quo [3];
        logic signed [34:0] at2 [3];
        logic signed [34:0] dep [3];
        logic signed [54:0] rc [9];
        logic signed [54:0] rd [9];
        out_t               res;
    } pipe_t;

endpackage

// ----- hw/rtl/sphere_box_contact.sv -----
// Top level of the sphere versus oriented box contact pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes one sphere centre and one box
//   pose per item. Output channel (out_valid / out_stall / out_item) returns one result
//   item per input item, in order: hit flag, world contact point, world depth vector.
//   Configuration: write radius and box half sizes through cfg_we / cfg_index / cfg_data
//   while the pipeline is empty; writes take effect on the next item.
// Timing:
//   The pipeline has 44 stages; out_valid rises once an accepted item has passed all
//   of them. One item enters per cycle while in_stall is low.
//   The stage count is set by the integer square root (two iterations per stage,
//   16 stages) and the three parallel restoring dividers (two quotient bits per
//   stage, 17 stages); the rest is matrix products, clamping and rounding.
// Reset:
//   rst_n clears all stage valid bits and loads the default radius (1.0) and half
//   sizes (0.5).
// Stall:
//   Each stage advances when it is empty or the stage after it advances, so bubbles
//   collapse and in_stall rises only when every stage holds an item and the output
//   is stalled. A stalled result holds on out_item unchanged.
module sphere_box_contact
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sbc_pkg::in_t             in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output sbc_pkg::out_t            out_item,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [sbc_pkg::CFG_W-1:0] cfg_data
);

    localparam int N = sbc_pkg::N_STG;

    // Configuration registers
    logic [sbc_pkg::CFG_W-1:0] radius_reg;
    logic [sbc_pkg::CFG_W-1:0] half_reg [3];
    logic [61:0]               lim_sq_reg;
    logic [61:0]               lim_sq_next;
    logic                      r_ok_reg;
    logic                      r_ok_next;
    logic [sbc_pkg::CFG_W-1:0] lim;

    // Pipeline
    sbc_pkg::pipe_t pipe_reg  [N];
    sbc_pkg::pipe_t pipe_next [N];
    logic [N-1:0]   v_reg;
    logic [N-1:0]   en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 31'd65536;
            half_reg[0] <= 31'd32768;
            half_reg[1] <= 31'd32768;
            half_reg[2] <= 31'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbc_pkg::REG_SPHERE_RADIUS: radius_reg  <= cfg_data;
                sbc_pkg::REG_HALF_SIZE_X:   half_reg[0] <= cfg_data;
                sbc_pkg::REG_HALF_SIZE_Y:   half_reg[1] <= cfg_data;
                sbc_pkg::REG_HALF_SIZE_Z:   half_reg[2] <= cfg_data;
            endcase
        end
    end

    // Squared contact limit, refreshed from the radius every cycle
    always_comb
    begin
        lim         = radius_reg - sbc_pkg::EPS_Q;
        lim_sq_next = lim * lim;
        r_ok_next   = (radius_reg >= sbc_pkg::EPS_Q);
    end

    always_ff @(posedge clk)
    begin
        lim_sq_reg <= lim_sq_next;
        r_ok_reg   <= r_ok_next;
    end

    // Advance chain: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || !out_stall;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[N-1];
    assign out_item  = pipe_reg[N-1].res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    if (i == 0)
                        v_reg[i] <= in_valid;
                    else
                        v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (en[i])
                pipe_reg[i] <= pipe_next[i];
        end
    end

    function automatic logic signed [19:0] rnd_m(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = (v + 35'sd8192) >>> 14;
        return t[19:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -43'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Stage: offset vector and rotation matrix from the quaternion
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [31:0] ii, jj, kk, ij, ik, jk, wi, wj, wk;
        logic signed [34:0] one;
        t   = '{default: '0};
        one = 35'sd268435456;
        ii  = in_item.rot_i * in_item.rot_i;
        jj  = in_item.rot_j * in_item.rot_j;
        kk  = in_item.rot_k * in_item.rot_k;
        ij  = in_item.rot_i * in_item.rot_j;
        ik  = in_item.rot_i * in_item.rot_k;
        jk  = in_item.rot_j * in_item.rot_k;
        wi  = in_item.rot_w * in_item.rot_i;
        wj  = in_item.rot_w * in_item.rot_j;
        wk  = in_item.rot_w * in_item.rot_k;
        t.m[0] = rnd_m(one - 35'sd2 * (35'(jj) + 35'(kk)));
        t.m[1] = rnd_m(35'sd2 * (35'(ij) - 35'(wk)));
        t.m[2] = rnd_m(35'sd2 * (35'(ik) + 35'(wj)));
        t.m[3] = rnd_m(35'sd2 * (35'(ij) + 35'(wk)));
        t.m[4] = rnd_m(one - 35'sd2 * (35'(ii) + 35'(kk)));
        t.m[5] = rnd_m(35'sd2 * (35'(jk) - 35'(wi)));
        t.m[6] = rnd_m(35'sd2 * (35'(ik) - 35'(wj)));
        t.m[7] = rnd_m(35'sd2 * (35'(jk) + 35'(wi)));
        t.m[8] = rnd_m(one - 35'sd2 * (35'(ii) + 35'(jj)));
        t.b[0] = in_item.box_x;
        t.b[1] = in_item.box_y;
        t.b[2] = in_item.box_z;
        t.d[0] = 33'(in_item.sphere_x) - 33'(in_item.box_x);
        t.d[1] = 33'(in_item.sphere_y) - 33'(in_item.box_y);
        t.d[2] = 33'(in_item.sphere_z) - 33'(in_item.box_z);
        pipe_next[sbc_pkg::ST_M] = t;
    end

    // Stage: products of the transposed matrix with the offset
    always_comb
    begin
        sbc_pkg::pipe_t t;
        t = pipe_reg[sbc_pkg::ST_PROD-1];
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t.prod[a*3+c] = t.m[c*3+a] * t.d[c];
            end
        end
        pipe_next[sbc_pkg::ST_PROD] = t;
    end

    // Stage: sum and round to the local centre
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [54:0] acc;
        t = pipe_reg[sbc_pkg::ST_PR-1];
        for (int a = 0; a < 3; a++)
        begin
            acc = 55'(t.prod[a*3]) + 55'(t.prod[a*3+1]) + 55'(t.prod[a*3+2]);
            t.pr[a] = 42'((acc + 55'sd8192) >>> 14);
        end
        pipe_next[sbc_pkg::ST_PR] = t;
    end

    // Stage: clamp to the box, offset from the clamped point
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [41:0] hs;
        logic signed [41:0] pc;
        logic signed [42:0] drw;
        logic signed [42:0] mg;
        logic signed [42:0] rs;
        t = pipe_reg[sbc_pkg::ST_CLAMP-1];
        t.border = 1'b0;
        t.near   = 1'b1;
        rs = 43'(radius_reg);
        for (int a = 0; a < 3; a++)
        begin
            hs = 42'(half_reg[a]);
            pc = t.pr[a];
            if (t.pr[a] < -hs)
            begin
                pc = -hs;
                t.border = 1'b1;
            end
            else if (t.pr[a] > hs)
            begin
                pc = hs;
                t.border = 1'b1;
            end
            t.p[a] = pc[31:0];
            drw = 43'(t.pr[a]) - 43'(pc);
            mg  = (drw < 0) ? -drw : drw;
            if (mg > rs)
                t.near = 1'b0;
            t.dmag[a] = mg[30:0];
            t.dr[a]   = drw[31:0];
        end
        pipe_next[sbc_pkg::ST_CLAMP] = t;
    end

    // Stage: squared offsets; nearest face for a centre inside the box
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [32:0] fd [6];
        logic signed [32:0] best;
        logic signed [34:0] hs, ps, rs;
        logic [2:0]         idx;
        logic [1:0]         ax;
        t = pipe_reg[sbc_pkg::ST_FACE-1];
        for (int a = 0; a < 3; a++)
        begin
            t.sq[a] = t.dmag[a] * t.dmag[a];
            fd[2*a]   = 33'(half_reg[a]) - 33'(t.p[a]);
            fd[2*a+1] = 33'(half_reg[a]) + 33'(t.p[a]);
        end
        // First strict minimum over +x,-x,+y,-y,+z,-z
        best = fd[0];
        idx  = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            if (fd[k] < best)
            begin
                best = fd[k];
                idx  = 3'(k);
            end
        end
        ax = idx[2:1];
        rs = 35'(radius_reg);
        for (int a = 0; a < 3; a++)
        begin
            hs = 35'(half_reg[a]);
            ps = 35'(t.p[a]);
            t.at2[a] = ps + ps;
            t.dep[a] = '0;
            if (ax == 2'(a))
            begin
                if (!idx[0])
                begin
                    t.at2[a] = hs + ps - rs;
                    t.dep[a] = hs - ps + rs;
                end
                else
                begin
                    t.at2[a] = -hs + ps + rs;
                    t.dep[a] = -hs - ps - rs;
                end
            end
        end
        t.interior = !t.border;
        pipe_next[sbc_pkg::ST_FACE] = t;
    end

    // Stage: squared distance and exact contact test
    always_comb
    begin
        sbc_pkg::pipe_t t;
        logic [63:0]    sum;
        t   = pipe_reg[sbc_pkg::ST_SUM-1];
        sum = 64'(t.sq[0]) + 64'(t.sq[1]) + 64'(t.sq[2]);
        t.cand = t.border && r_ok_reg && t.near && (sum <= 64'(lim_sq_reg));
        t.hit  = t.interior || t.cand;
        t.sq_n = sum;
        t.sq_r = '0;
        pipe_next[sbc_pkg::ST_SUM] = t;
    end

    // Integer square root, digit by digit from the top bit pair
    for (genvar gs = 0; gs < sbc_pkg::SQ_STG; gs++)
    begin : g_sqrt
        always_comb
        begin
            sbc_pkg::pipe_t t;
            logic [63:0]    bt;
            logic [63:0]    rb;
            t = pipe_reg[sbc_pkg::ST_SQRT0+gs-1];
            for (int s = 0; s < sbc_pkg::SQ_PER; s++)
            begin
                bt = 64'd1 << (62 - 2 * (gs * sbc_pkg::SQ_PER + s));
                rb = t.sq_r + bt;
                if (t.sq_n >= rb)
                begin
                    t.sq_n = t.sq_n - rb;
                    t.sq_r = (t.sq_r >> 1) + bt;
                end
                else
                begin
                    t.sq_r = t.sq_r >> 1;
                end
            end
            pipe_next[sbc_pkg::ST_SQRT0+gs] = t;
        end
    end

    // Stage: radius times offset magnitude
    always_comb
    begin
        sbc_pkg::pipe_t t;
        t      = pipe_reg[sbc_pkg::ST_NUM-1];
        t.root = t.sq_r[31:0];
        for (int a = 0; a < 3; a++)
        begin
            t.num[a] = radius_reg * t.dmag[a];
        end
        pipe_next[sbc_pkg::ST_NUM] = t;
    end

    // Stage: add half the divisor for round to nearest
    always_comb
    begin
        sbc_pkg::pipe_t t;
        t = pipe_reg[sbc_pkg::ST_ADD-1];
        for (int a = 0; a < 3; a++)
        begin
            t.rem[a] = 64'(t.num[a]) + 64'(t.root >> 1);
            t.quo[a] = '0;
        end
        pipe_next[sbc_pkg::ST_ADD] = t;
    end

    // Restoring division, three lanes side by side
    for (genvar gd = 0; gd < sbc_pkg::DIV_STG; gd++)
    begin : g_div
        always_comb
        begin
            sbc_pkg::pipe_t t;
            logic [63:0]    dk;
            int             k;
            t = pipe_reg[sbc_pkg::ST_DIV0+gd-1];
            for (int s = 0; s < sbc_pkg::DIV_PER; s++)
            begin
                k = sbc_pkg::DIV_BITS - 1 - (gd * sbc_pkg::DIV_PER + s);
                if (k >= 0)
                begin
                    dk = 64'(t.root) << k;
                    for (int a = 0; a < 3; a++)
                    begin
                        if (t.rem[a] >= dk)
                        begin
                            t.rem[a]    = t.rem[a] - dk;
                            t.quo[a][k] = 1'b1;
                        end
                    end
                end
            end
            pipe_next[sbc_pkg::ST_DIV0+gd] = t;
        end
    end

    // Stage: signed scaled direction, local contact and depth
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [34:0] sc;
        logic signed [34:0] ps;
        logic signed [34:0] ds;
        t = pipe_reg[sbc_pkg::ST_SC-1];
        for (int a = 0; a < 3; a++)
        begin
            sc = 35'(t.quo[a]);
            ps = 35'(t.p[a]);
            ds = 35'(t.dr[a]);
            if (t.dr[a] < 0)
                sc = -sc;
            if (t.cand)
            begin
                t.dep[a] = sc - ds;
                t.at2[a] = ps + ps + ds - sc;
            end
            else if (!t.hit)
            begin
                t.dep[a] = '0;
                t.at2[a] = '0;
            end
        end
        pipe_next[sbc_pkg::ST_SC] = t;
    end

    // Stage: rotate back to world frame
    always_comb
    begin
        sbc_pkg::pipe_t t;
        t = pipe_reg[sbc_pkg::ST_ROT-1];
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t.rc[a*3+c] = t.m[a*3+c] * t.at2[c];
                t.rd[a*3+c] = t.m[a*3+c] * t.dep[c];
            end
        end
        pipe_next[sbc_pkg::ST_ROT] = t;
    end

    // Stage: sum, round, offset by the box centre, saturate
    always_comb
    begin
        sbc_pkg::pipe_t     t;
        logic signed [56:0] ac, ad;
        logic signed [42:0] cw [3];
        logic signed [42:0] dw [3];
        t = pipe_reg[sbc_pkg::ST_OUT-1];
        for (int a = 0; a < 3; a++)
        begin
            ac = 57'(t.rc[a*3]) + 57'(t.rc[a*3+1]) + 57'(t.rc[a*3+2]);
            ad = 57'(t.rd[a*3]) + 57'(t.rd[a*3+1]) + 57'(t.rd[a*3+2]);
            cw[a] = 43'((ac + 57'sd16384) >>> 15) + 43'(t.b[a]);
            dw[a] = 43'((ad + 57'sd8192) >>> 14);
        end
        t.res = '0;
        if (t.hit)
        begin
            t.res.hit       = 1'b1;
            t.res.contact_x = sat32(cw[0]);
            t.res.contact_y = sat32(cw[1]);
            t.res.contact_z = sat32(cw[2]);
            t.res.depth_x   = sat32(dw[0]);
            t.res.depth_y   = sat32(dw[1]);
            t.res.depth_z   = sat32(dw[2]);
        end
        pipe_next[sbc_pkg::ST_OUT] = t;
    end

    // Input may back up only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    // A miss carries all-zero geometry
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.hit) |->
        (out_item.contact_x == 0 && out_item.contact_y == 0 && out_item.contact_z == 0 &&
         out_item.depth_x == 0 && out_item.depth_y == 0 && out_item.depth_z == 0))
        else $error("miss with nonzero contact or depth");

    // Surface contact only for a centre outside the box
    a_cand_border: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[sbc_pkg::ST_SUM] && pipe_reg[sbc_pkg::ST_SUM].cand) |->
        (pipe_reg[sbc_pkg::ST_SUM].border && !pipe_reg[sbc_pkg::ST_SUM].interior))
        else $error("surface contact flagged for inside centre");

endmodule

// ----- bench/tb_sphere_box_contact.sv -----
// Testbench for the sphere versus oriented box contact pipeline.
`timescale 1ns / 1ps

module tb_sphere_box_contact;

    localparam int LATENCY = 44;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] EPS_LSB = 64'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    sbc_pkg::in_t in_item;
    logic out_valid;
    logic out_stall;
    sbc_pkg::out_t out_item;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [sbc_pkg::CFG_W-1:0] cfg_data;

    // Predictor copies of the configuration registers
    longint radius_q;
    longint half_q [3];

    sbc_pkg::out_t expected_contacts [$];
    int error_count;
    int cycle_count;
    int idle_pct_in;
    int idle_pct_out;
    int hold_off_cycles;

    sphere_box_contact u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Division by 2^n rounded to nearest, ties up, built on the floor that >>> gives on signed longint
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs_val(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (n >= root + bit_w)
            begin
                n -= root + bit_w;
                root = (root >> 1) + bit_w;
            end
            else
                root >>= 1;
            bit_w >>= 2;
        end
        return root;
    endfunction

    // Work out the contact that one sphere/box pair should give
    function automatic sbc_pkg::out_t predict_contact(sbc_pkg::in_t it);
        longint bc [3];
        longint dv [3];
        longint rm [3][3];
        longint pr [3];
        longint pc [3];
        longint at2 [3];
        longint dep [3];
        longint w, qi, qj, qk, acc, best, fd, sg, ac, ad;
        bit border, hit, near;
        int idx, ax;
        longint dr [3];
        longint unsigned sum, lim, root_len, num;
        longint sc;
        sbc_pkg::out_t res;
        bc[0] = it.box_x;
        bc[1] = it.box_y;
        bc[2] = it.box_z;
        dv[0] = longint'(it.sphere_x) - bc[0];
        dv[1] = longint'(it.sphere_y) - bc[1];
        dv[2] = longint'(it.sphere_z) - bc[2];
        w = it.rot_w;
        qi = it.rot_i;
        qj = it.rot_j;
        qk = it.rot_k;
        rm[0][0] = (longint'(1) << 28) - 2 * (qj * qj + qk * qk);
        rm[0][1] = 2 * (qi * qj - w * qk);
        rm[0][2] = 2 * (qi * qk + w * qj);
        rm[1][0] = 2 * (qi * qj + w * qk);
        rm[1][1] = (longint'(1) << 28) - 2 * (qi * qi + qk * qk);
        rm[1][2] = 2 * (qj * qk - w * qi);
        rm[2][0] = 2 * (qi * qk - w * qj);
        rm[2][1] = 2 * (qj * qk + w * qi);
        rm[2][2] = (longint'(1) << 28) - 2 * (qi * qi + qj * qj);
        for (int a = 0; a < 3; a++)
            for (int c = 0; c < 3; c++)
                rm[a][c] = round_shift(rm[a][c], 14);
        border = 1'b0;
        hit = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += rm[c][a] * dv[c];
            pr[a] = round_shift(acc, 14);
            pc[a] = pr[a];
            if (pc[a] < -half_q[a])
            begin
                pc[a] = -half_q[a];
                border = 1'b1;
            end
            else if (pc[a] > half_q[a])
            begin
                pc[a] = half_q[a];
                border = 1'b1;
            end
            at2[a] = 0;
            dep[a] = 0;
        end
        if (!border)
        begin
            // Inside: push out through the nearest face, first strict minimum wins
            best = half_q[0] - pc[0];
            idx = 0;
            for (int k = 1; k < 6; k++)
            begin
                fd = (k & 1) ? half_q[k >> 1] + pc[k >> 1] : half_q[k >> 1] - pc[k >> 1];
                if (fd < best)
                begin
                    best = fd;
                    idx = k;
                end
            end
            ax = idx >> 1;
            sg = (idx & 1) ? -1 : 1;
            for (int a = 0; a < 3; a++)
                at2[a] = 2 * pc[a];
            at2[ax] = sg * half_q[ax] + pc[ax] - sg * radius_q;
            dep[ax] = sg * half_q[ax] - pc[ax] + sg * radius_q;
            hit = 1'b1;
        end
        else if (radius_q >= longint'(EPS_LSB))
        begin
            sum = 0;
            lim = longint'(radius_q) - longint'(EPS_LSB);
            near = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                dr[a] = pr[a] - pc[a];
                if (abs_val(dr[a]) > radius_q)
                    near = 1'b0;
            end
            if (near)
            begin
                for (int a = 0; a < 3; a++)
                    sum += longint'(abs_val(dr[a])) * longint'(abs_val(dr[a]));
                if (sum <= lim * lim)
                begin
                    root_len = floor_sqrt(sum);
                    for (int a = 0; a < 3; a++)
                    begin
                        num = radius_q * abs_val(dr[a]);
                        sc = (num + root_len / 2) / root_len;
                        if (dr[a] < 0)
                            sc = -sc;
                        dep[a] = sc - dr[a];
                        at2[a] = pc[a] + pr[a] - sc;
                    end
                    hit = 1'b1;
                end
            end
        end
        res = '0;
        if (hit)
        begin
            res.hit = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                ac = 0;
                ad = 0;
                for (int c = 0; c < 3; c++)
                begin
                    ac += rm[a][c] * at2[c];
                    ad += rm[a][c] * dep[c];
                end
                ac = sat_word(bc[a] + round_shift(ac, 15));
                ad = sat_word(round_shift(ad, 14));
                case (a)
                    0:
                    begin
                        res.contact_x = ac[31:0];
                        res.depth_x = ad[31:0];
                    end
                    1:
                    begin
                        res.contact_y = ac[31:0];
                        res.depth_y = ad[31:0];
                    end
                    default:
                    begin
                        res.contact_z = ac[31:0];
                        res.depth_z = ad[31:0];
                    end
                endcase
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one item: predict, then hold valid until accepted; valid stays up for the next
    task automatic send_pair(sbc_pkg::in_t it);
        while (idle_pct_in != 0 && $urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        expected_contacts = {expected_contacts, predict_contact(it)};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The predictor's copy changes at the same edge as the register; the pipe is empty here
    task automatic write_reg(logic [1:0] idx, longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[sbc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sbc_pkg::REG_SPHERE_RADIUS)
            radius_q = value;
        else
            half_q[idx - 1] = value;
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (expected_contacts.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic sbc_pkg::in_t rand_pair(longint span, bit unit_rot);
        sbc_pkg::in_t it;
        longint q [4];
        it.box_x = $urandom;
        it.box_y = $urandom;
        it.box_z = $urandom;
        if ($urandom_range(9) == 0)
        begin
            it.sphere_x = $urandom;
            it.sphere_y = $urandom;
            it.sphere_z = $urandom;
        end
        else
        begin
            // Keep the centre near the box so contacts are common
            it.box_x = $signed($urandom) >>> $urandom_range(12, 1);
            it.box_y = $signed($urandom) >>> $urandom_range(12, 1);
            it.box_z = $signed($urandom) >>> $urandom_range(12, 1);
            it.sphere_x = 32'(longint'(it.box_x) +
                              longint'($urandom_range(32'(2 * span))) - span);
            it.sphere_y = 32'(longint'(it.box_y) +
                              longint'($urandom_range(32'(2 * span))) - span);
            it.sphere_z = 32'(longint'(it.box_z) +
                              longint'($urandom_range(32'(2 * span))) - span);
        end
        if (unit_rot)
        begin
            // Approximately unit quaternion from a random direction
            longint n2, nr;
            for (int i = 0; i < 4; i++)
                q[i] = longint'($urandom_range(32768)) - 16384;
            n2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
            nr = floor_sqrt(n2);
            if (nr == 0)
            begin
                q[0] = 16384;
                nr = 16384;
            end
            for (int i = 0; i < 4; i++)
                q[i] = q[i] * 16384 / nr;
        end
        else
            for (int i = 0; i < 4; i++)
                q[i] = longint'($urandom_range(32768)) - 16384;
        it.rot_w = q[0][15:0];
        it.rot_i = q[1][15:0];
        it.rot_j = q[2][15:0];
        it.rot_k = q[3][15:0];
        return it;
    endfunction

    function automatic sbc_pkg::in_t axis_pair(longint sx, longint sy, longint sz,
                                               longint bx, longint by, longint bz);
        sbc_pkg::in_t it;
        it.sphere_x = sx[31:0];
        it.sphere_y = sy[31:0];
        it.sphere_z = sz[31:0];
        it.box_x = bx[31:0];
        it.box_y = by[31:0];
        it.box_z = bz[31:0];
        it.rot_w = 16'sd16384;
        it.rot_i = '0;
        it.rot_j = '0;
        it.rot_k = '0;
        return it;
    endfunction

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_contacts.size() == 0)
            begin
                report_mismatch("extra result", out_item.hit, 0);
            end
            else
            begin
                sbc_pkg::out_t want;
                want = expected_contacts.pop_front();
                if (out_item.hit !== want.hit)
                    report_mismatch("hit", out_item.hit, want.hit);
                if (out_item.contact_x !== want.contact_x)
                    report_mismatch("contact_x", out_item.contact_x, want.contact_x);
                if (out_item.contact_y !== want.contact_y)
                    report_mismatch("contact_y", out_item.contact_y, want.contact_y);
                if (out_item.contact_z !== want.contact_z)
                    report_mismatch("contact_z", out_item.contact_z, want.contact_z);
                if (out_item.depth_x !== want.depth_x)
                    report_mismatch("depth_x", out_item.depth_x, want.depth_x);
                if (out_item.depth_y !== want.depth_y)
                    report_mismatch("depth_y", out_item.depth_y, want.depth_y);
                if (out_item.depth_z !== want.depth_z)
                    report_mismatch("depth_z", out_item.depth_z, want.depth_z);
            end
        end
    end

    // Drive the receiver stall; a hold-off request wins over random idling
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= (idle_pct_out != 0) && ($urandom_range(99) < idle_pct_out);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("tb_sphere_box_contact failed");
            $finish;
        end
    end

    task automatic test_face_pushout();
        // Centre at the box centre: ties resolve to +x
        send_pair(axis_pair(0, 0, 0, 0, 0, 0));
        // Nearest face along +x, -x, -y and +z; the +y and -z items put the centre outside the box
        send_pair(axis_pair(30000, 0, 0, 0, 0, 0));
        send_pair(axis_pair(-30000, 0, 0, 0, 0, 0));
        send_pair(axis_pair(0, 30000, 0, 65536, 0, 0));
        send_pair(axis_pair(0, -30000, 0, 0, 0, 0));
        send_pair(axis_pair(0, 0, 30000, 0, 0, 0));
        send_pair(axis_pair(0, 0, -30000, 0, -65536, 0));
        // Exactly on the surface counts as inside
        send_pair(axis_pair(32768, 0, 0, 0, 0, 0));
    endtask

    task automatic test_outside_contact();
        send_pair(axis_pair(32768 + 65536 - 8, 0, 0, 0, 0, 0));
        send_pair(axis_pair(32768 + 65536 - 7, 0, 0, 0, 0, 0));
        send_pair(axis_pair(32768 + 65536 - 6, 0, 0, 0, 0, 0));
        send_pair(axis_pair(60000, 60000, 60000, 0, 0, 0));
        send_pair(axis_pair(-60000, -50000, 40000, 0, 0, 0));
        // Far away and full-scale extremes
        send_pair(axis_pair(32'sh7fffffff, -32'sh80000000, 0, -32'sh80000000, 32'sh7fffffff, 0));
        send_pair(axis_pair(-1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_rotations();
        sbc_pkg::in_t it;
        it = axis_pair(50000, 10000, -20000, 0, 0, 0);
        it.rot_w = 16'sd11585;
        it.rot_k = 16'sd11585;
        send_pair(it);
        // Non-unit quaternions at the range limits
        it.rot_w = -16'sd16384;
        it.rot_i = 16'sd16384;
        it.rot_j = -16'sd16384;
        it.rot_k = 16'sd16384;
        send_pair(it);
        it.rot_w = '0;
        it.rot_i = '0;
        it.rot_j = '0;
        it.rot_k = '0;
        send_pair(it);
        it = axis_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       -32'sh80000000, -32'sh80000000, -32'sh80000000);
        it.rot_i = 16'sd16384;
        it.rot_w = 16'sd0;
        send_pair(it);
        drain_pipe();
    endtask

    task automatic test_register_extremes();
        // Tiny radius: outside centres never touch
        write_reg(sbc_pkg::REG_SPHERE_RADIUS, 6);
        send_pair(axis_pair(32770, 0, 0, 0, 0, 0));
        send_pair(axis_pair(20000, 0, 0, 0, 0, 0));
        drain_pipe();
        write_reg(sbc_pkg::REG_SPHERE_RADIUS, 0);
        write_reg(sbc_pkg::REG_HALF_SIZE_X, 0);
        write_reg(sbc_pkg::REG_HALF_SIZE_Y, 0);
        write_reg(sbc_pkg::REG_HALF_SIZE_Z, 0);
        send_pair(axis_pair(0, 0, 0, 0, 0, 0));
        send_pair(axis_pair(1, 0, 0, 0, 0, 0));
        drain_pipe();
        write_reg(sbc_pkg::REG_SPHERE_RADIUS, 31'h7fffffff);
        write_reg(sbc_pkg::REG_HALF_SIZE_X, 31'h7fffffff);
        write_reg(sbc_pkg::REG_HALF_SIZE_Y, 31'h7fffffff);
        write_reg(sbc_pkg::REG_HALF_SIZE_Z, 31'h7fffffff);
        send_pair(axis_pair(32'sh7fffffff, 0, 0, -32'sh80000000, 0, 0));
        send_pair(axis_pair(123456, -654321, 99, 0, 0, 0));
        drain_pipe();
    endtask

    task automatic test_random_settings(int count, longint rad, longint hx, longint hy,
                                        longint hz, longint span);
        write_reg(sbc_pkg::REG_SPHERE_RADIUS, rad);
        write_reg(sbc_pkg::REG_HALF_SIZE_X, hx);
        write_reg(sbc_pkg::REG_HALF_SIZE_Y, hy);
        write_reg(sbc_pkg::REG_HALF_SIZE_Z, hz);
        for (int i = 0; i < count; i++)
            send_pair(rand_pair(span, $urandom_range(3) != 0));
        drain_pipe();
    endtask

    task automatic test_back_pressure();
        // Hold the output long enough to fill the pipe and stall the input
        hold_off_cycles = 150;
        for (int i = 0; i < 80; i++)
            send_pair(rand_pair(200000, 1'b1));
        // Pause until every result has come, then resume
        drain_pipe();
        for (int i = 0; i < 20; i++)
            send_pair(rand_pair(200000, 1'b1));
        drain_pipe();
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        idle_pct_in = 10;
        idle_pct_out = 10;
        radius_q = 65536;
        half_q[0] = 32768;
        half_q[1] = 32768;
        half_q[2] = 32768;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = sbc_pkg::REG_SPHERE_RADIUS;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_face_pushout();
        test_outside_contact();
        test_rotations();
        test_register_extremes();
        test_random_settings(150, 65536, 32768, 32768, 32768, 200000);
        // Long stretch with no idling on either side
        idle_pct_in = 0;
        idle_pct_out = 0;
        test_random_settings(120, 200000, 100000, 20000, 300000, 500000);
        idle_pct_in = 10;
        idle_pct_out = 10;
        test_random_settings(120, 3000, 1000, 700000, 5000, 20000);
        test_random_settings(80, 31'h7fffffff, 31'h7fffffff, 65536, 0, 32'sh7fffffff);
        test_back_pressure();
        test_random_settings(80, 7, 65536, 65536, 65536, 70000);

        drain_pipe();
        if (error_count == 0 && expected_contacts.size() == 0)
            $display("tb_sphere_box_contact passed");
        else
            $display("tb_sphere_box_contact failed");
        $finish;
    end

endmodule
